FILE: rtl/assert_macros.svh
// assertion macros for the rtl blocks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/sec_pkg.sv
// types and constants for the steering end-stop calibrator
`default_nettype none

package sec_pkg;

  localparam int HISTORY_DEPTH_DEF = 20;

  localparam int POS_W   = 32;
  localparam int REG_W   = 8;
  localparam int CMD_W   = 9;
  localparam int MODE_W  = 2;
  localparam int PHASE_W = 3;
  localparam int CFG_IDX_W = 2;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 48;

  localparam logic [REG_W-1:0] DRIVE_SPEED_RST  = 8'd30;
  localparam logic [REG_W-1:0] LEFT_SPINUP_RST  = 8'd20;
  localparam logic [REG_W-1:0] RIGHT_SPINUP_RST = 8'd50;
  localparam logic [REG_W-1:0] SPINUP_COUNT_RST = 8'd20;

  typedef enum logic [PHASE_W-1:0] {
    PH_INIT   = 3'd0,
    PH_WAIT   = 3'd1,
    PH_LEFT   = 3'd2,
    PH_RIGHT  = 3'd3,
    PH_CENTER = 3'd4,
    PH_READY  = 3'd5
  } phase_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK   = 2'd0,
    MODE_CAL    = 2'd1,
    MODE_TARGET = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DRIVE_SPEED  = 2'd0,
    CFG_LEFT_SPINUP  = 2'd1,
    CFG_RIGHT_SPINUP = 2'd2
  } cfg_idx_t;

endpackage

`default_nettype wire

FILE: rtl/steering_endstop_calibrator_unit.sv
// steering end-stop calibrator: homing to both stops, centering and bang-bang hold
// usage:
//   s_* carries one request per accepted beat: s_tuser holds the mode (control
//   tick, calibrate, set hold target), s_tdata the position and the new target.
//   m_* returns exactly one result per request, in order: command flag, signed
//   speed command, ready flag, phase and the computed centre.
//   cfg_we/cfg_index/cfg_data write drive_speed, left_spinup and right_spinup;
//   write them only while no request is in flight.
// path: a request moves from the input register into the result register as soon as
//   the result register is empty or its result is being taken.
// throughput: 1 request per cycle while results are taken; the phase, stop and spin-up registers update
//   as a request moves into the result register, so the next one sees them.
// velocity uses a shift line of HISTORY_DEPTH-2 past positions, written only on
//   ticks in the left and right phases.
// reset: phase goes to init, stops, centre, target and history clear, spin-up
//   count loads 20, config registers take their defaults; both valids drop.
// stall: when m_tready is low the result holds and the input register still
//   takes one more request; after that s_tready drops until the result leaves.
`default_nettype none

module steering_endstop_calibrator_unit #(
  parameter int HISTORY_DEPTH = sec_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // position [31:0], new_target [63:32]
  input  wire logic [sec_pkg::IN_DATA_W-1:0]      s_tdata,
  // mode [1:0]
  input  wire logic [sec_pkg::MODE_W-1:0]         s_tuser,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // speed_write [0], speed_cmd [9:1], ready_res [10], phase [13:11],
  // center_position [45:14], zero [47:46]
  output logic [sec_pkg::OUT_DATA_W-1:0]          m_tdata,
  input  wire logic                               cfg_we,
  input  wire logic [sec_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [sec_pkg::REG_W-1:0]          cfg_data
);

  `include "assert_macros.svh"

  localparam int LAG = HISTORY_DEPTH - 2;

  // config registers
  logic [sec_pkg::REG_W-1:0] drive_speed;
  logic [sec_pkg::REG_W-1:0] left_spinup;
  logic [sec_pkg::REG_W-1:0] right_spinup;

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_speed  <= sec_pkg::DRIVE_SPEED_RST;
      left_spinup  <= sec_pkg::LEFT_SPINUP_RST;
      right_spinup <= sec_pkg::RIGHT_SPINUP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sec_pkg::CFG_DRIVE_SPEED:  drive_speed  <= cfg_data;
        sec_pkg::CFG_LEFT_SPINUP:  left_spinup  <= cfg_data;
        sec_pkg::CFG_RIGHT_SPINUP: right_spinup <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  logic                                in_valid;
  logic [sec_pkg::MODE_W-1:0]          in_mode;
  logic signed [sec_pkg::POS_W-1:0]    in_pos;
  logic signed [sec_pkg::POS_W-1:0]    in_tgt;
  logic                                adv;

  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_mode <= s_tuser;
      in_pos  <= s_tdata[sec_pkg::POS_W-1:0];
      in_tgt  <= s_tdata[2*sec_pkg::POS_W-1:sec_pkg::POS_W];
    end
  end

  // controller state
  sec_pkg::phase_t                   phase_reg, phase_next;
  logic [sec_pkg::REG_W-1:0]         spinup_count, spinup_count_next;
  logic signed [sec_pkg::POS_W-1:0]  left_stop, left_stop_next;
  logic signed [sec_pkg::POS_W-1:0]  right_stop, right_stop_next;
  logic signed [sec_pkg::POS_W-1:0]  center_reg, center_reg_next;
  logic signed [sec_pkg::POS_W-1:0]  hold_target, hold_target_next;
  logic signed [sec_pkg::POS_W-1:0]  hist [LAG];
  logic                              push;

  logic                              wr;
  logic signed [sec_pkg::CMD_W-1:0]  cmd;
  logic signed [sec_pkg::CMD_W-1:0]  spd_pos;
  logic signed [sec_pkg::CMD_W-1:0]  spd_neg;
  logic signed [sec_pkg::POS_W:0]    vel;
  logic signed [sec_pkg::POS_W:0]    stop_sum;
  logic signed [sec_pkg::POS_W:0]    hold_err;
  logic                              vel_le0;
  logic                              vel_neg;

  assign spd_pos  = signed'({1'b0, drive_speed});
  assign spd_neg  = -spd_pos;
  assign vel      = {in_pos[sec_pkg::POS_W-1], in_pos}
                  - {hist[LAG-1][sec_pkg::POS_W-1], hist[LAG-1]};
  assign vel_neg  = vel[sec_pkg::POS_W];
  assign vel_le0  = vel_neg || (vel == '0);
  assign stop_sum = {left_stop[sec_pkg::POS_W-1], left_stop} + {in_pos[sec_pkg::POS_W-1], in_pos};
  assign hold_err = {hold_target[sec_pkg::POS_W-1], hold_target}
                  - {in_pos[sec_pkg::POS_W-1], in_pos};

  always_comb begin
    phase_next        = phase_reg;
    spinup_count_next = spinup_count;
    left_stop_next    = left_stop;
    right_stop_next   = right_stop;
    center_reg_next   = center_reg;
    hold_target_next  = hold_target;
    push              = 1'b0;
    wr                = 1'b0;
    cmd               = '0;
    unique case (in_mode)
      sec_pkg::MODE_CAL: begin
        if (phase_reg == sec_pkg::PH_WAIT) begin
          phase_next        = sec_pkg::PH_LEFT;
          spinup_count_next = left_spinup;
        end
      end
      sec_pkg::MODE_TARGET: begin
        hold_target_next = in_tgt;
      end
      sec_pkg::MODE_TICK: begin
        unique case (phase_reg)
          sec_pkg::PH_INIT: begin
            left_stop_next  = '0;
            right_stop_next = '0;
            center_reg_next = '0;
            phase_next      = sec_pkg::PH_WAIT;
          end
          sec_pkg::PH_LEFT: begin
            wr   = 1'b1;
            cmd  = spd_pos;
            push = 1'b1;
            if (spinup_count == '0) begin
              if (vel_le0) begin
                left_stop_next    = in_pos;
                phase_next        = sec_pkg::PH_RIGHT;
                spinup_count_next = right_spinup;
              end
            end else if (!vel_le0) begin
              spinup_count_next = spinup_count - 1'b1;
            end
          end
          sec_pkg::PH_RIGHT: begin
            wr   = 1'b1;
            cmd  = spd_neg;
            push = 1'b1;
            if (spinup_count == '0) begin
              if (!vel_neg) begin
                cmd             = '0;
                right_stop_next = in_pos;
                center_reg_next = stop_sum[sec_pkg::POS_W:1];
                phase_next      = sec_pkg::PH_CENTER;
              end
            end else if (vel_neg) begin
              spinup_count_next = spinup_count - 1'b1;
            end
          end
          sec_pkg::PH_CENTER: begin
            wr = 1'b1;
            priority if (center_reg > in_pos) begin
              cmd = spd_pos;
            end else if (center_reg < in_pos) begin
              cmd = spd_neg;
            end else begin
              hold_target_next = center_reg;
              phase_next       = sec_pkg::PH_READY;
            end
          end
          sec_pkg::PH_READY: begin
            wr = 1'b1;
            priority if (hold_err > 33'sd1) begin
              cmd = spd_pos;
            end else if (hold_err < -33'sd1) begin
              cmd = spd_neg;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg    <= sec_pkg::PH_INIT;
      spinup_count <= sec_pkg::SPINUP_COUNT_RST;
      left_stop    <= '0;
      right_stop   <= '0;
      center_reg   <= '0;
      hold_target  <= '0;
      for (int i = 0; i < LAG; i++) begin
        hist[i] <= '0;
      end
    end else if (adv) begin
      phase_reg    <= phase_next;
      spinup_count <= spinup_count_next;
      left_stop    <= left_stop_next;
      right_stop   <= right_stop_next;
      center_reg   <= center_reg_next;
      hold_target  <= hold_target_next;
      if (push) begin
        hist[0] <= in_pos;
        for (int i = 1; i < LAG; i++) begin
          hist[i] <= hist[i-1];
        end
      end
    end
  end

  // result register
  logic                              out_write;
  logic signed [sec_pkg::CMD_W-1:0]  out_cmd;
  logic                              out_ready;
  sec_pkg::phase_t                   out_phase;
  logic signed [sec_pkg::POS_W-1:0]  out_center;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_write  <= wr;
      out_cmd    <= cmd;
      out_ready  <= (phase_next == sec_pkg::PH_READY);
      out_phase  <= phase_next;
      out_center <= center_reg_next;
    end
  end

  assign m_tdata = {2'b00, out_center, out_phase, out_ready, out_cmd, out_write};

  // checks
  `ASSERT_CLK(a_cmd_zero_no_write, clk, rst,
    m_tvalid && !out_write |-> out_cmd == '0, "command without write flag")
  `ASSERT_CLK(a_ready_matches_phase, clk, rst,
    m_tvalid |-> out_ready == (out_phase == sec_pkg::PH_READY), "ready flag mismatch")
  `ASSERT_CLK(a_phase_holds_idle, clk, rst,
    !adv |=> $stable(phase_reg), "phase moved without a request")
  `ASSERT_CLK(a_right_spinup_load, clk, rst,
    adv && phase_reg == sec_pkg::PH_LEFT && phase_next == sec_pkg::PH_RIGHT
      |=> spinup_count == right_spinup, "right spin-up count not loaded")

endmodule

`default_nettype wire
